// ===== design/complex_arithmetic_unit_assert.svh =====
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define CAU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its cause.
`define CAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/cau_pkg.sv =====
package cau_pkg;

  localparam int WORD_BITS   = 32;
  localparam int FRAC_BITS   = 16;
  localparam int PROD_BITS   = 2 * WORD_BITS;
  localparam int DIRECT_BITS = 2 * WORD_BITS + 1;
  localparam int NUM_BITS    = 2 * WORD_BITS + FRAC_BITS;
  localparam int QUO_BITS    = WORD_BITS + 1;
  localparam int DIV_CELLS   = QUO_BITS;

  localparam logic signed [DIRECT_BITS-1:0] SAT_MAX =
    {{(DIRECT_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [DIRECT_BITS-1:0] SAT_MIN = ~SAT_MAX;
  localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ORD_LT = 2'd0,
    ORD_EQ = 2'd1,
    ORD_GT = 2'd2
  } order_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_DZ  = 2'd1,
    ST_SAT = 2'd2
  } status_e;

  // One result part on its way through the divider chain.
  typedef struct packed {
    logic                          neg;
    logic                          ovf;
    logic [QUO_BITS-1:0]           n;
    logic [PROD_BITS-1:0]          rem;
    logic [QUO_BITS-1:0]           q;
    logic signed [DIRECT_BITS-1:0] direct;
  } part_t;

  typedef struct packed {
    logic [2:0]           op;
    logic [1:0]           order;
    logic                 dz;
    logic [PROD_BITS-1:0] den;
    part_t                re;
    part_t                im;
  } item_t;

endpackage

// ===== design/cau_in_if.sv =====
interface cau_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [2:0]                             operation;
  logic signed [cau_pkg::WORD_BITS-1:0]   a_re;
  logic signed [cau_pkg::WORD_BITS-1:0]   a_im;
  logic signed [cau_pkg::WORD_BITS-1:0]   b_re;
  logic signed [cau_pkg::WORD_BITS-1:0]   b_im;

  modport source (output valid, operation, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, operation, a_re, a_im, b_re, b_im, output ready);
endinterface

// ===== design/cau_out_if.sv =====
interface cau_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [cau_pkg::WORD_BITS-1:0]   result_re;
  logic signed [cau_pkg::WORD_BITS-1:0]   result_im;
  logic [1:0]                             order;
  logic [1:0]                             status;

  modport source (output valid, result_re, result_im, order, status, input ready);
  modport sink   (input valid, result_re, result_im, order, status, output ready);
endinterface

// ===== design/cau_front.sv =====
module cau_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic [2:0]                           operation_i,
  input  logic signed [cau_pkg::WORD_BITS-1:0] a_re_i,
  input  logic signed [cau_pkg::WORD_BITS-1:0] a_im_i,
  input  logic signed [cau_pkg::WORD_BITS-1:0] b_re_i,
  input  logic signed [cau_pkg::WORD_BITS-1:0] b_im_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output cau_pkg::item_t                       item_o
);
  import cau_pkg::*;

  function automatic part_t div_init(logic signed [DIRECT_BITS-1:0] num,
                                     logic [PROD_BITS-1:0] den,
                                     logic signed [DIRECT_BITS-1:0] direct);
    part_t                 p;
    logic [PROD_BITS-1:0]  mag;
    logic [NUM_BITS-1:0]   nv;
    logic [PROD_BITS-1:0]  hi;
    mag = num[DIRECT_BITS-1] ? PROD_BITS'(-num) : PROD_BITS'(num);
    nv  = {mag, {FRAC_BITS{1'b0}}};
    hi  = PROD_BITS'(nv[NUM_BITS-1:QUO_BITS]);
    p.neg    = num[DIRECT_BITS-1];
    // quotient needs more than QUO_BITS bits: saturate
    p.ovf    = (hi >= den);
    p.rem    = p.ovf ? '0 : hi;
    p.n      = nv[QUO_BITS-1:0];
    p.q      = '0;
    p.direct = direct;
    return p;
  endfunction

  // stage 1: products, order, add/sub
  logic                          s1_valid_q;
  logic [2:0]                    s1_op_q;
  logic [1:0]                    s1_order_q, s1_order_d;
  logic                          s1_dz_q;
  logic signed [WORD_BITS:0]     s1_sre_q, s1_sim_q, s1_sre_d, s1_sim_d;
  logic signed [PROD_BITS-1:0]   s1_rr_q, s1_ii_q, s1_ri_q, s1_ir_q, s1_bb_q, s1_cc_q;
  // stage 2: sums of products
  logic                          s2_valid_q;
  logic [2:0]                    s2_op_q;
  logic [1:0]                    s2_order_q;
  logic                          s2_dz_q;
  logic [PROD_BITS-1:0]          s2_den_q, s2_den_d;
  logic signed [DIRECT_BITS-1:0] s2_dre_q, s2_dim_q, s2_dre_d, s2_dim_d;
  logic signed [DIRECT_BITS-1:0] s2_nre_q, s2_nim_q, s2_nre_d, s2_nim_d;
  logic signed [DIRECT_BITS-1:0] mre, mim;
  // stage 3: divider setup
  logic                          s3_valid_q;
  item_t                         s3_item_q, s3_item_d;

  logic s1_ready, s2_ready, s3_ready;

  assign s3_ready = !s3_valid_q || ready_i;
  assign s2_ready = !s2_valid_q || s3_ready;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign ready_o  = s1_ready;
  assign valid_o  = s3_valid_q;
  assign item_o   = s3_item_q;

  always_comb begin
    if (a_re_i < b_re_i || (a_re_i == b_re_i && a_im_i < b_im_i)) begin
      s1_order_d = ORD_LT;
    end else if (a_re_i == b_re_i && a_im_i == b_im_i) begin
      s1_order_d = ORD_EQ;
    end else begin
      s1_order_d = ORD_GT;
    end
    if (operation_i == OP_SUB) begin
      s1_sre_d = (WORD_BITS+1)'(a_re_i) - (WORD_BITS+1)'(b_re_i);
      s1_sim_d = (WORD_BITS+1)'(a_im_i) - (WORD_BITS+1)'(b_im_i);
    end else begin
      s1_sre_d = (WORD_BITS+1)'(a_re_i) + (WORD_BITS+1)'(b_re_i);
      s1_sim_d = (WORD_BITS+1)'(a_im_i) + (WORD_BITS+1)'(b_im_i);
    end
  end

  always_comb begin
    mre      = (DIRECT_BITS'(s1_rr_q) - DIRECT_BITS'(s1_ii_q)) >>> FRAC_BITS;
    mim      = (DIRECT_BITS'(s1_ri_q) + DIRECT_BITS'(s1_ir_q)) >>> FRAC_BITS;
    s2_den_d = $unsigned(s1_bb_q) + $unsigned(s1_cc_q);
    s2_nre_d = DIRECT_BITS'(s1_rr_q) + DIRECT_BITS'(s1_ii_q);
    s2_nim_d = DIRECT_BITS'(s1_ir_q) - DIRECT_BITS'(s1_ri_q);
    case (s1_op_q)
      OP_ADD, OP_SUB: begin
        s2_dre_d = DIRECT_BITS'(s1_sre_q);
        s2_dim_d = DIRECT_BITS'(s1_sim_q);
      end
      OP_MUL: begin
        s2_dre_d = mre;
        s2_dim_d = mim;
      end
      default: begin
        s2_dre_d = '0;
        s2_dim_d = '0;
      end
    endcase
  end

  always_comb begin
    s3_item_d.op    = s2_op_q;
    s3_item_d.order = s2_order_q;
    s3_item_d.dz    = s2_dz_q;
    s3_item_d.den   = s2_den_q;
    s3_item_d.re    = div_init(s2_nre_q, s2_den_q, s2_dre_q);
    s3_item_d.im    = div_init(s2_nim_q, s2_den_q, s2_dim_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s3_ready) s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && valid_i) begin
      s1_op_q    <= operation_i;
      s1_order_q <= s1_order_d;
      s1_dz_q    <= (b_re_i == '0) && (b_im_i == '0);
      s1_sre_q   <= s1_sre_d;
      s1_sim_q   <= s1_sim_d;
      s1_rr_q    <= PROD_BITS'(a_re_i) * PROD_BITS'(b_re_i);
      s1_ii_q    <= PROD_BITS'(a_im_i) * PROD_BITS'(b_im_i);
      s1_ri_q    <= PROD_BITS'(a_re_i) * PROD_BITS'(b_im_i);
      s1_ir_q    <= PROD_BITS'(a_im_i) * PROD_BITS'(b_re_i);
      s1_bb_q    <= PROD_BITS'(b_re_i) * PROD_BITS'(b_re_i);
      s1_cc_q    <= PROD_BITS'(b_im_i) * PROD_BITS'(b_im_i);
    end
    if (s2_ready && s1_valid_q) begin
      s2_op_q    <= s1_op_q;
      s2_order_q <= s1_order_q;
      s2_dz_q    <= s1_dz_q;
      s2_den_q   <= s2_den_d;
      s2_dre_q   <= s2_dre_d;
      s2_dim_q   <= s2_dim_d;
      s2_nre_q   <= s2_nre_d;
      s2_nim_q   <= s2_nim_d;
    end
    if (s3_ready && s2_valid_q) begin
      s3_item_q <= s3_item_d;
    end
  end

endmodule

// ===== design/cau_div_cell.sv =====
module cau_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  cau_pkg::item_t item_i,
  output logic           valid_o,
  input  logic           ready_i,
  output cau_pkg::item_t item_o
);
  import cau_pkg::*;

  // One restoring step: bring down the next numerator bit, try to subtract.
  function automatic part_t div_step(part_t p, logic [PROD_BITS-1:0] den);
    part_t              r;
    logic [PROD_BITS:0] rs;
    logic               ge;
    rs = {p.rem, p.n[QUO_BITS-1]};
    ge = (rs >= {1'b0, den});
    r          = p;
    r.rem      = ge ? PROD_BITS'(rs - {1'b0, den}) : rs[PROD_BITS-1:0];
    r.q        = {p.q[QUO_BITS-2:0], ge};
    r.n        = {p.n[QUO_BITS-2:0], 1'b0};
    return r;
  endfunction

  logic  valid_q;
  item_t item_q, item_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_comb begin
    item_d    = item_i;
    item_d.re = div_step(item_i.re, item_i.den);
    item_d.im = div_step(item_i.im, item_i.den);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) item_q <= item_d;
  end

endmodule

// ===== design/cau_tail.sv =====
`include "complex_arithmetic_unit_assert.svh"

module cau_tail (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  cau_pkg::item_t                       item_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic signed [cau_pkg::WORD_BITS-1:0] result_re_o,
  output logic signed [cau_pkg::WORD_BITS-1:0] result_im_o,
  output logic [1:0]                           order_o,
  output logic [1:0]                           status_o
);
  import cau_pkg::*;

  // Returns {saturated, value}.
  function automatic logic [WORD_BITS:0] finish(part_t p, logic is_div);
    logic signed [DIRECT_BITS-1:0] v;
    logic signed [DIRECT_BITS-1:0] qx;
    logic signed [WORD_BITS-1:0]   w;
    logic                          s;
    qx = p.ovf ? (DIRECT_BITS'(1) << QUO_BITS) : DIRECT_BITS'(p.q);
    if (is_div) begin
      v = p.neg ? -qx : qx;
    end else begin
      v = p.direct;
    end
    if (v > SAT_MAX) begin
      w = WORD_MAX;
      s = 1'b1;
    end else if (v < SAT_MIN) begin
      w = WORD_MIN;
      s = 1'b1;
    end else begin
      w = v[WORD_BITS-1:0];
      s = 1'b0;
    end
    return {s, w};
  endfunction

  logic                        valid_q;
  logic signed [WORD_BITS-1:0] re_q, im_q, re_d, im_d;
  logic [1:0]                  order_q;
  status_e                     status_q, status_d;
  logic                        is_div, load;
  logic [WORD_BITS:0]          fre, fim;

  assign ready_o     = !valid_q || ready_i;
  assign load        = ready_o && valid_i;
  assign valid_o     = valid_q;
  assign result_re_o = re_q;
  assign result_im_o = im_q;
  assign order_o     = order_q;
  assign status_o    = status_q;

  assign is_div = (item_i.op == OP_DIV);

  always_comb begin
    fre = finish(item_i.re, is_div);
    fim = finish(item_i.im, is_div);
    if (is_div && item_i.dz) begin
      re_d     = '0;
      im_d     = '0;
      status_d = ST_DZ;
    end else begin
      re_d     = fre[WORD_BITS-1:0];
      im_d     = fim[WORD_BITS-1:0];
      status_d = (fre[WORD_BITS] || fim[WORD_BITS]) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      re_q     <= re_d;
      im_q     <= im_d;
      order_q  <= item_i.order;
      status_q <= status_d;
    end
  end

  `CAU_ASSERT_NEXT(a_dz_zero, load && is_div && item_i.dz, status_q == ST_DZ && re_q == '0 && im_q == '0, "divide by zero item left nonzero result")
  `CAU_ASSERT_NOW(a_sat_bound, valid_q && status_q == ST_SAT, re_q == WORD_MAX || re_q == WORD_MIN || im_q == WORD_MAX || im_q == WORD_MIN, "saturated item has no clamped part")
  `CAU_ASSERT_NEXT(a_cmp_zero, load && item_i.op != OP_ADD && item_i.op != OP_SUB && item_i.op != OP_MUL && item_i.op != OP_DIV, re_q == '0 && im_q == '0 && status_q == ST_OK, "compare item produced a result")

endmodule

// ===== design/complex_arithmetic_unit.sv =====
// Channel  Direction  Payload
// in_i     sink       operation, a_re, a_im, b_re, b_im
// out_o    source     result_re, result_im, order, status
//
// One item per cycle sustained while out_o is ready; operands and results are Q16.16.
// Three front stages form products, sums and divider setup; a chain of
// WORD_BITS + 1 divider cells yields one quotient bit each; one output stage.
// Reset clears only the stage valid flags.
// A stalled output holds only the stages behind it that are full; empty
// stages keep filling, so input is taken while a result waits.
module complex_arithmetic_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  cau_in_if.sink     in_i,
  cau_out_if.source  out_o
);
  import cau_pkg::*;

  logic  cell_valid [DIV_CELLS+1];
  logic  cell_ready [DIV_CELLS+1];
  item_t cell_item  [DIV_CELLS+1];

  cau_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_i.valid),
    .ready_o     (in_i.ready),
    .operation_i (in_i.operation),
    .a_re_i      (in_i.a_re),
    .a_im_i      (in_i.a_im),
    .b_re_i      (in_i.b_re),
    .b_im_i      (in_i.b_im),
    .valid_o     (cell_valid[0]),
    .ready_i     (cell_ready[0]),
    .item_o      (cell_item[0])
  );

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
    cau_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cell_valid[i]),
      .ready_o (cell_ready[i]),
      .item_i  (cell_item[i]),
      .valid_o (cell_valid[i+1]),
      .ready_i (cell_ready[i+1]),
      .item_o  (cell_item[i+1])
    );
  end

  cau_tail u_tail (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (cell_valid[DIV_CELLS]),
    .ready_o     (cell_ready[DIV_CELLS]),
    .item_i      (cell_item[DIV_CELLS]),
    .valid_o     (out_o.valid),
    .ready_i     (out_o.ready),
    .result_re_o (out_o.result_re),
    .result_im_o (out_o.result_im),
    .order_o     (out_o.order),
    .status_o    (out_o.status)
  );

endmodule
